// ===== hdl/mand_pkg.sv =====
// Shared types, reset values and register indexes for the escape-time iterator.
package mand_pkg;

    localparam int FRAC_BITS_DEF = 28;

    localparam int COORD_W  = 12;
    localparam int ITER_W   = 16;
    localparam int MAG_W    = 32;
    localparam int STEP_W   = 31;
    localparam int ORIGIN_W = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;

    localparam logic signed [ORIGIN_W-1:0] X_ORIGIN_RST = -32'sd536870912;
    localparam logic signed [ORIGIN_W-1:0] Y_ORIGIN_RST = -32'sd300647711;
    localparam logic [STEP_W-1:0]          X_STEP_RST   = 31'd828794;
    localparam logic [STEP_W-1:0]          Y_STEP_RST   = 31'd751619;
    localparam logic [ITER_W-1:0]          ITER_LIM_RST = 16'd1000;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } t_in_word;

    typedef struct packed {
        logic [COORD_W-1:0] out_column;
        logic [COORD_W-1:0] out_row;
        logic [ITER_W-1:0]  iterations;
        logic               inside_res;
        logic [MAG_W-1:0]   magnitude_squared;
    } t_out_word;

endpackage

// ===== hdl/mand_mul.sv =====
// Shared multi-cycle multiplier: a by b, b taken 32 bits a cycle from the top.
module mand_mul import mand_pkg::*; #(
    parameter int MW  = 32,
    parameter int NCH = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [MW-1:0]         i_a,
    input  logic [MW-1:0]         i_b,
    output logic [MW+NCH*32-1:0]  o_prod,
    output logic                  o_done
);

    localparam int BW    = NCH * 32;
    localparam int PRODW = MW + BW;
    localparam int PARTW = MW + 32;
    localparam int LW    = $clog2(NCH + 1);

    logic [MW-1:0]    r_a;
    logic [BW-1:0]    r_b;
    logic [PRODW-1:0] r_acc;
    logic [LW-1:0]    r_left;
    logic             r_done;

    logic [BW-1:0]    b_pad;
    logic [MW-1:0]    a_op;
    logic [31:0]      chunk;
    logic [PARTW-1:0] part;

    assign b_pad = BW'(i_b);
    assign a_op  = i_start ? i_a : r_a;
    assign chunk = i_start ? b_pad[BW-1 -: 32] : r_b[BW-1 -: 32];
    assign part  = PARTW'(a_op) * PARTW'(chunk);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= b_pad << 32;
            r_acc <= PRODW'(part);
        end else if (r_left != '0) begin
            r_b   <= r_b << 32;
            r_acc <= (r_acc << 32) + PRODW'(part);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_left <= LW'(NCH - 1);
            r_done <= (NCH == 1);
        end else begin
            if (r_left != '0) r_left <= r_left - LW'(1);
            r_done <= (r_left == LW'(1));
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

// ===== hdl/mandelbrot_escape_iterator.sv =====
// Each word runs two coordinate products and then three products per iteration through
// the single shared multiplier, whose operands are max(FRAC_BITS+4, 31) bits wide. The
// core works on one word at a time: a new word is accepted only after the previous result
// has been parked in the output register.
// Reset (synchronous, active low) returns the sequencer to idle, drops the result valid
// and reloads the configuration registers with their defaults.
module mandelbrot_escape_iterator import mand_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // z parts: signed Q4.F
    localparam int ZW    = FRAC_BITS + 4;
    // multiplier operand width, wide enough for |z| and for the step registers
    localparam int MW    = (ZW > STEP_W) ? ZW : STEP_W;
    localparam int NCH   = (MW + 31) / 32;
    localparam int PRODW = MW + NCH * 32;
    // exact coordinate: 32-bit origin plus 12x31-bit product
    localparam int CW    = 45;
    // squares (Q7.F, unsigned), their sum (Q8.F, unsigned), and the half-shifted cross product
    localparam int SQW   = FRAC_BITS + 7;
    localparam int SUMW  = FRAC_BITS + 8;
    localparam int PW    = FRAC_BITS + 8;
    // working width for the next-z sums before saturation
    localparam int SW    = FRAC_BITS + 9;
    // rescale of |z|^2 to 24 fraction bits
    localparam int SHR   = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
    localparam int SHL   = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;
    localparam int SCW   = SUMW + SHL;

    localparam logic [SUMW-1:0] FOUR = SUMW'(4) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FX,   // waiting on column * x_step
        ST_FY,   // waiting on row * y_step
        ST_XY,   // waiting on |zx|*|zy|
        ST_SQX,  // waiting on zx^2
        ST_SQY,  // waiting on zy^2, then escape test
        ST_FIN
    } t_state;

    // config
    logic signed [ORIGIN_W-1:0] r_x_origin, r_y_origin;
    logic [STEP_W-1:0]          r_x_step, r_y_step;
    logic [ITER_W-1:0]          r_limit;

    t_state                     r_state;
    logic [COORD_W-1:0]         r_col, r_row;
    logic signed [ZW-1:0]       r_cx, r_cy, r_zx, r_zy;
    logic [SQW-1:0]             r_zx2, r_zy2;
    logic [ITER_W-1:0]          r_iter;
    logic                       r_neg;
    logic                       r_out_valid;
    t_out_word                  r_out_word;

    // shared multiplier
    logic                       mul_start;
    logic [MW-1:0]              mul_a, mul_b;
    logic [PRODW-1:0]           prod;
    logic                       mul_done;

    mand_mul #(
        .MW  (MW),
        .NCH (NCH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (prod),
        .o_done  (mul_done)
    );

    function automatic logic signed [ZW-1:0] sat_z(input logic signed [SW-1:0] v);
        logic ovf;
        ovf = (v[SW-1:ZW-1] != {(SW-ZW+1){v[SW-1]}});
        if (ovf) sat_z = v[SW-1] ? {1'b1, {(ZW-1){1'b0}}} : {1'b0, {(ZW-1){1'b1}}};
        else     sat_z = v[ZW-1:0];
    endfunction

    function automatic logic signed [ZW-1:0] sat_c(input logic signed [CW-1:0] v);
        logic ovf;
        ovf = (v[CW-1:ZW-1] != {(CW-ZW+1){v[CW-1]}});
        if (ovf) sat_c = v[CW-1] ? {1'b1, {(ZW-1){1'b0}}} : {1'b0, {(ZW-1){1'b1}}};
        else     sat_c = v[ZW-1:0];
    endfunction

    function automatic logic [MW-1:0] mag_z(input logic signed [ZW-1:0] v);
        logic [ZW-1:0] m;
        m = v[ZW-1] ? ZW'(-v) : ZW'(v);
        mag_z = MW'(m);
    endfunction

    // coordinate forming, one adder shared by both axes
    logic signed [ORIGIN_W-1:0] org;
    logic signed [CW-1:0]       c_full;
    logic [CW-1:0]              c_mag;
    logic                       snap;
    logic signed [ZW-1:0]       c_sat;

    assign org    = (r_state == ST_FX) ? r_x_origin : r_y_origin;
    assign c_full = CW'(org) + $signed({1'b0, prod[CW-2:0]});
    assign c_mag  = c_full[CW-1] ? CW'(-c_full) : CW'(c_full);
    // imaginary part snapped to the axis inside half a row step
    assign snap   = ({c_mag, 1'b0} < (CW + 1)'(r_y_step));
    assign c_sat  = sat_c(c_full);

    // iteration datapath
    logic [SQW-1:0]       sq;
    logic [PW-1:0]        pxy;
    logic signed [SW-1:0] pxy_s, zy_sum, zx_sum;
    logic [SUMW-1:0]      esc_sum;
    logic [ITER_W-1:0]    it_next;
    logic                 cont;

    assign sq      = prod[FRAC_BITS +: SQW];
    // 2*zx*zy: shift by one fewer bit
    assign pxy     = prod[FRAC_BITS-1 +: PW];
    assign pxy_s   = $signed({1'b0, pxy});
    assign zy_sum  = (r_neg ? -pxy_s : pxy_s) + SW'(r_cy);
    assign zx_sum  = $signed({2'b00, r_zx2}) - $signed({2'b00, sq}) + SW'(r_cx);
    assign esc_sum = SUMW'(r_zx2) + SUMW'(sq);
    assign it_next = r_iter + ITER_W'(1);
    assign cont    = (it_next < r_limit) && (esc_sum < FOUR);

    // result formatting
    logic [SUMW-1:0] fin_sum;
    logic [SCW-1:0]  scaled;
    logic            mag_sat;

    assign fin_sum = SUMW'(r_zx2) + SUMW'(r_zy2);
    assign scaled  = (SCW'(fin_sum) << SHL) >> SHR;
    assign mag_sat = (scaled > SCW'(32'hFFFF_FFFF));

    // multiplier issue: next product starts in the cycle the previous one is used
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            ST_IDLE: begin
                mul_start = i_in_valid;
                mul_a     = MW'(i_in_word.column);
                mul_b     = MW'(r_x_step);
            end
            ST_FX: begin
                mul_start = mul_done;
                mul_a     = MW'(r_row);
                mul_b     = MW'(r_y_step);
            end
            ST_FY: begin
                // first pass: z is zero, so the cross product is zero
                mul_start = mul_done && (r_limit != '0);
            end
            ST_XY: begin
                mul_start = mul_done;
                mul_a     = mag_z(r_zx);
                mul_b     = mag_z(r_zx);
            end
            ST_SQX: begin
                mul_start = mul_done;
                mul_a     = mag_z(r_zy);
                mul_b     = mag_z(r_zy);
            end
            ST_SQY: begin
                mul_start = mul_done && cont;
                mul_a     = mag_z(r_zx);
                mul_b     = mag_z(r_zy);
            end
            ST_FIN: begin
                mul_start = 1'b0;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_x_origin  <= X_ORIGIN_RST;
            r_y_origin  <= Y_ORIGIN_RST;
            r_x_step    <= X_STEP_RST;
            r_y_step    <= Y_STEP_RST;
            r_limit     <= ITER_LIM_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_X_ORIGIN:   r_x_origin <= i_cfg_data;
                    REG_Y_ORIGIN:   r_y_origin <= i_cfg_data;
                    REG_X_STEP:     r_x_step   <= i_cfg_data[STEP_W-1:0];
                    REG_Y_STEP:     r_y_step   <= i_cfg_data[STEP_W-1:0];
                    REG_ITER_LIMIT: r_limit    <= i_cfg_data[ITER_W-1:0];
                    default: ;
                endcase
            end

            // the finish state reloads the result register itself
            if (r_out_valid && i_out_ready && (r_state != ST_FIN)) r_out_valid <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_col   <= i_in_word.column;
                        r_row   <= i_in_word.row;
                        r_state <= ST_FX;
                    end
                end
                ST_FX: begin
                    if (mul_done) begin
                        r_cx    <= c_sat;
                        r_state <= ST_FY;
                    end
                end
                ST_FY: begin
                    if (mul_done) begin
                        r_cy    <= snap ? '0 : c_sat;
                        // z starts at zero, so the first new zx is cx
                        r_zx    <= r_cx;
                        r_zy    <= '0;
                        r_zx2   <= '0;
                        r_zy2   <= '0;
                        r_iter  <= '0;
                        r_neg   <= 1'b0;
                        r_state <= (r_limit == '0) ? ST_FIN : ST_XY;
                    end
                end
                ST_XY: begin
                    if (mul_done) begin
                        r_zy    <= sat_z(zy_sum);
                        r_state <= ST_SQX;
                    end
                end
                ST_SQX: begin
                    if (mul_done) begin
                        r_zx2   <= sq;
                        r_state <= ST_SQY;
                    end
                end
                ST_SQY: begin
                    if (mul_done) begin
                        r_zy2  <= sq;
                        r_iter <= it_next;
                        if (cont) begin
                            // sign of the cross product from z before update
                            r_neg   <= r_zx[ZW-1] ^ r_zy[ZW-1];
                            r_zx    <= sat_z(zx_sum);
                            r_state <= ST_XY;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    // output register frees the core as soon as the word is parked
                    if (!r_out_valid || i_out_ready) begin
                        r_out_word.out_column        <= r_col;
                        r_out_word.out_row           <= r_row;
                        r_out_word.iterations        <= r_iter;
                        r_out_word.inside_res        <= (r_iter == r_limit);
                        r_out_word.magnitude_squared <= mag_sat ? '1 : scaled[MAG_W-1:0];
                        r_out_valid                  <= 1'b1;
                        r_state                      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== tb/tb_mandelbrot_escape_iterator.sv =====
// Self-checking testbench for the escape-time iterator: directed table, then random views.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_iterator;
    import mand_pkg::*;

    // --------------------------------------------------------------------
    // Constants
    // --------------------------------------------------------------------
    localparam int FRAC = FRAC_BITS_DEF;

    // z parts live in Q4.FRAC and clip to [-8, 8)
    localparam longint Z_HI      = (64'sd8 <<< FRAC) - 1;
    localparam longint Z_LO      = -(64'sd8 <<< FRAC);
    localparam longint ESCAPE_R2 = 64'sd4 <<< FRAC;

    localparam logic signed [ORIGIN_W-1:0] ORG_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [ORIGIN_W-1:0] ORG_MIN  = 32'sh8000_0000;
    localparam logic [STEP_W-1:0]          STEP_MAX = 31'h7FFF_FFFF;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          N_GROUPS    = 12;   // random views, four per idling phase
    localparam int          GROUP_WORDS = 50;
    localparam int          TAIL_CYCLES = 64;   // quiet spell after the last result

    // Register image kept by the testbench, written only through write_reg
    typedef struct packed {
        logic signed [ORIGIN_W-1:0] x_origin;
        logic signed [ORIGIN_W-1:0] y_origin;
        logic [STEP_W-1:0]          x_step;
        logic [STEP_W-1:0]          y_step;
        logic [ITER_W-1:0]          iter_limit;
    } t_view;

    localparam t_view RESET_VIEW = '{X_ORIGIN_RST, Y_ORIGIN_RST, X_STEP_RST, Y_STEP_RST,
                                     ITER_LIM_RST};

    // One directed pixel: the view it needs, the pixel, and, where it is obvious,
    // the expected iterations / inside flag / magnitude (typed = 1)
    typedef struct packed {
        t_view              v;
        t_in_word           px;
        logic               typed;
        logic [ITER_W-1:0]  iters;
        logic               in_set;
        logic [MAG_W-1:0]   mag_sq;
    } t_dir_row;

    localparam int N_DIR = 21;

    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        // default view straight after reset: corners, the bulb, beyond the range
        '{RESET_VIEW, '{12'd0, 12'd0}, 1'b0, 16'd0, 1'b0, 32'd0},
        '{RESET_VIEW, '{12'd799, 12'd599}, 1'b0, 16'd0, 1'b0, 32'd0},
        '{RESET_VIEW, '{12'd400, 12'd300}, 1'b0, 16'd0, 1'b0, 32'd0},
        '{RESET_VIEW, '{12'd4095, 12'd4095}, 1'b0, 16'd0, 1'b0, 32'd0},
        // row 400 lands a hair off the real axis, so the imaginary part snaps to zero
        '{RESET_VIEW, '{12'd650, 12'd400}, 1'b0, 16'd0, 1'b0, 32'd0},
        // zero limit: nothing iterates, counts as inside
        '{'{X_ORIGIN_RST, Y_ORIGIN_RST, X_STEP_RST, Y_STEP_RST, 16'd0},
          '{12'd123, 12'd456}, 1'b1, 16'd0, 1'b1, 32'd0},
        // c = 0 stays at z = 0 until the limit
        '{'{32'sd0, 32'sd0, X_STEP_RST, Y_STEP_RST, 16'd1},
          '{12'd0, 12'd0}, 1'b1, 16'd1, 1'b1, 32'd0},
        '{'{32'sd0, 32'sd0, X_STEP_RST, Y_STEP_RST, 16'd20},
          '{12'd0, 12'd0}, 1'b1, 16'd20, 1'b1, 32'd0},
        // origin corners: escape on the first step with the largest squares
        '{'{ORG_MAX, ORG_MAX, 31'd0, 31'd0, 16'd1000},
          '{12'd0, 12'd0}, 1'b1, 16'd1, 1'b0, 32'h7FFF_FFFE},
        '{'{ORG_MIN, ORG_MIN, 31'd0, 31'd0, 16'd1000},
          '{12'd0, 12'd0}, 1'b1, 16'd1, 1'b0, 32'h8000_0000},
        // position * step far past the range clips c, largest limit
        '{'{ORG_MAX, ORG_MAX, STEP_MAX, STEP_MAX, 16'hFFFF},
          '{12'd4095, 12'd4095}, 1'b1, 16'd1, 1'b0, 32'h7FFF_FFFE},
        // single step on the real axis, both ends; limit reached as it escapes
        '{'{ORG_MAX, 32'sd0, 31'd0, 31'd0, 16'd1},
          '{12'd0, 12'd0}, 1'b1, 16'd1, 1'b1, 32'h3FFF_FFFF},
        '{'{ORG_MIN, 32'sd0, 31'd0, 31'd0, 16'd1},
          '{12'd0, 12'd0}, 1'b1, 16'd1, 1'b1, 32'h4000_0000},
        // alternating bit patterns in the pixel position
        '{'{X_ORIGIN_RST, Y_ORIGIN_RST, 31'd100000, 31'd90000, 16'd32},
          '{12'hAAA, 12'h555}, 1'b0, 16'd0, 1'b0, 32'd0},
        '{'{X_ORIGIN_RST, Y_ORIGIN_RST, 31'd100000, 31'd90000, 16'd32},
          '{12'h555, 12'hAAA}, 1'b0, 16'd0, 1'b0, 32'd0},
        // snap band edges at row 5 with y step 1000: cy = +500, +499, -499, -500.
        // c sits on the chaotic stretch of the real axis so a stray cy grows.
        '{'{-32'sd510027366, -32'sd4500, 31'd0, 31'd1000, 16'd255},
          '{12'd0, 12'd5}, 1'b0, 16'd0, 1'b0, 32'd0},
        '{'{-32'sd510027366, -32'sd4501, 31'd0, 31'd1000, 16'd255},
          '{12'd0, 12'd5}, 1'b0, 16'd0, 1'b0, 32'd0},
        '{'{-32'sd510027366, -32'sd5499, 31'd0, 31'd1000, 16'd255},
          '{12'd0, 12'd5}, 1'b0, 16'd0, 1'b0, 32'd0},
        '{'{-32'sd510027366, -32'sd5500, 31'd0, 31'd1000, 16'd255},
          '{12'd0, 12'd5}, 1'b0, 16'd0, 1'b0, 32'd0},
        // deep point near the neck, full default limit
        '{'{-32'sd201326592, 32'sd26843546, 31'd0, 31'd0, 16'd1000},
          '{12'd0, 12'd0}, 1'b0, 16'd0, 1'b0, 32'd0},
        // most negative origin plus largest step: exact sum lands back in range
        '{'{ORG_MIN, ORG_MIN, STEP_MAX, STEP_MAX, 16'd64},
          '{12'd1, 12'd2}, 1'b0, 16'd0, 1'b0, 32'd0}
    };

    // --------------------------------------------------------------------
    // DUT signals, inputs all known from time zero
    // --------------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    mandelbrot_escape_iterator #(
        .FRAC_BITS (FRAC)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // --------------------------------------------------------------------
    // Testbench state
    // --------------------------------------------------------------------
    t_view       view = RESET_VIEW;     // register image as the DUT should hold it
    t_out_word   pending_pixels[$];     // expected result words, oldest first
    int          faults      = 0;
    int          src_idle    = 37;      // percent of cycles the sender holds back
    int          sink_idle   = 87;      // percent of cycles the receiver stalls
    int unsigned cycle_count = 0;

    // --------------------------------------------------------------------
    // Escape-time predictor
    // --------------------------------------------------------------------
    function automatic longint clip_z(input longint v);
        if (v > Z_HI) return Z_HI;
        if (v < Z_LO) return Z_LO;
        return v;
    endfunction

    function automatic longint unsigned abs_q(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic t_out_word escape_time(input t_in_word px);
        longint          cx, cy, zx, zy, zy_new, zx_sq, zy_sq, prod;
        longint unsigned sum_q;
        int unsigned     n;
        t_out_word       res;
        // c formed exactly, snapped on the exact imaginary part, then clipped
        cx = longint'($signed(view.x_origin)) + longint'(px.column) * longint'(view.x_step);
        cy = longint'($signed(view.y_origin)) + longint'(px.row) * longint'(view.y_step);
        if (2 * abs_q(cy) < longint'(view.y_step))
            cy = 0;
        cx = clip_z(cx);
        cy = clip_z(cy);
        zx    = 0;
        zy    = 0;
        zx_sq = 0;
        zy_sq = 0;
        n     = 0;
        while (n < 32'(view.iter_limit) && zx_sq + zy_sq < ESCAPE_R2) begin
            // 2*zx*zy: magnitude product truncated, sign applied afterwards
            prod = longint'((abs_q(zx) * abs_q(zy)) >> (FRAC - 1));
            if ((zx < 0) != (zy < 0))
                prod = -prod;
            zy_new = clip_z(prod + cy);
            zx     = clip_z(zx_sq - zy_sq + cx);
            zy     = zy_new;
            zx_sq  = longint'((abs_q(zx) * abs_q(zx)) >> FRAC);
            zy_sq  = longint'((abs_q(zy) * abs_q(zy)) >> FRAC);
            n++;
        end
        // Q8.FRAC down to Q8.24, saturating
        sum_q                 = longint'(zx_sq + zy_sq) >> (FRAC - 24);
        res.out_column        = px.column;
        res.out_row           = px.row;
        res.iterations        = ITER_W'(n);
        res.inside_res        = (n == 32'(view.iter_limit));
        res.magnitude_squared = (sum_q > 64'hFFFF_FFFF) ? '1 : MAG_W'(sum_q);
        return res;
    endfunction

    // --------------------------------------------------------------------
    // Stimulus helpers (all called just after a rising edge)
    // --------------------------------------------------------------------
    // Leaves the write enable high; the caller drops it after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_X_ORIGIN:   view.x_origin   = data;
            REG_Y_ORIGIN:   view.y_origin   = data;
            REG_X_STEP:     view.x_step     = data[STEP_W-1:0];
            REG_Y_STEP:     view.y_step     = data[STEP_W-1:0];
            REG_ITER_LIMIT: view.iter_limit = data[ITER_W-1:0];
            default: ;      // unused index, no register behind it
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_view(input t_view v);
        write_reg(REG_X_ORIGIN, v.x_origin);
        write_reg(REG_Y_ORIGIN, v.y_origin);
        write_reg(REG_X_STEP, 32'(v.x_step));
        write_reg(REG_Y_STEP, 32'(v.y_step));
        write_reg(REG_ITER_LIMIT, 32'(v.iter_limit));
    endtask

    // Sender holds back until every result has been taken
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    // Offers one pixel word; valid stays up after acceptance so that a
    // back-to-back word never sees valid dropped and raised in one step
    task automatic send_pixel(input t_in_word px, input t_out_word want);
        while ($urandom_range(0, 99) < src_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= px;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pending_pixels.push_back(want);
    endtask

    // --------------------------------------------------------------------
    // Result side: random stalls and field-by-field checking
    // --------------------------------------------------------------------
    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            faults++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        i_out_ready <= ($urandom_range(0, 99) >= sink_idle);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("result word for column %0d row %0d with nothing pending",
                       o_out_word.out_column, o_out_word.out_row);
                faults++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("out_column", want.out_column, o_out_word.out_column);
                check_field("out_row", want.out_row, o_out_word.out_row);
                check_field("iterations", want.iterations, o_out_word.iterations);
                check_field("inside_res", want.inside_res, o_out_word.inside_res);
                check_field("magnitude_squared", want.magnitude_squared,
                            o_out_word.magnitude_squared);
            end
        end
    end

    // Watchdog against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // --------------------------------------------------------------------
    // Main sequence
    // --------------------------------------------------------------------
    initial begin
        t_view       nv;
        t_in_word    px;
        t_out_word   want;
        int unsigned zero_row;
        int unsigned ystep;
        bit          wide_view;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; the view is reprogrammed only when a row needs another
        for (int k = 0; k < N_DIR; k++) begin
            if (DIR_ROWS[k].v != view) begin
                wait_drained();
                program_view(DIR_ROWS[k].v);
                i_cfg_we <= 1'b0;
            end
            px = DIR_ROWS[k].px;
            if (DIR_ROWS[k].typed)
                want = '{px.column, px.row, DIR_ROWS[k].iters, DIR_ROWS[k].in_set,
                         DIR_ROWS[k].mag_sq};
            else
                want = escape_time(px);
            send_pixel(px, want);
        end

        // Random views. Most frame the set itself with a row that crosses the
        // real axis (zero_row), so the snap band is hit regularly; every fourth
        // view is wholly random, origins and steps to full width.
        for (int g = 0; g < N_GROUPS; g++) begin
            wait_drained();
            case (g / 4)
                0: begin
                    src_idle  = 37;
                    sink_idle = 87;
                end
                1: begin
                    src_idle  = 87;
                    sink_idle = 37;
                end
                default: begin
                    src_idle  = 0;
                    sink_idle = 0;
                end
            endcase

            wide_view = (g % 4 == 3);
            zero_row  = $urandom_range(0, 4095);
            if (wide_view) begin
                nv.x_origin = $signed($urandom);
                nv.y_origin = $signed($urandom);
                nv.x_step   = STEP_W'($urandom);
                nv.y_step   = STEP_W'($urandom);
            end else begin
                // real origin from -2.5 to +0.5, view at most about two units across
                nv.x_origin = $signed($urandom_range(0, 805306368)) - 32'sd671088640;
                nv.x_step   = STEP_W'($urandom_range(0, 1 << 17));
                nv.y_step   = STEP_W'($urandom_range(0, 1 << 17));
                ystep       = 32'(nv.y_step);
                nv.y_origin = $signed($urandom_range(0, 2 * ystep) - ystep * (zero_row + 1));
            end
            // one slower view with a deeper limit; the rest stay short
            nv.iter_limit = (g == 5) ? ITER_W'(250) : ITER_W'($urandom_range(0, 64));
            program_view(nv);
            // unused indexes must leave every register alone
            if (g == 0)
                for (int idx = int'(REG_ITER_LIMIT) + 1; idx < (1 << CFG_IDX_W); idx++)
                    write_reg(CFG_IDX_W'(idx), $urandom);
            i_cfg_we <= 1'b0;

            for (int w = 0; w < GROUP_WORDS; w++) begin
                // now and then the sender waits for the pipe to empty
                if (w != 0 && $urandom_range(0, 31) == 0)
                    wait_drained();
                px.column = COORD_W'($urandom_range(0, 4095));
                px.row    = ($urandom_range(0, 3) == 0) ? COORD_W'(zero_row)
                                                        : COORD_W'($urandom_range(0, 4095));
                send_pixel(px, escape_time(px));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (faults == 0 && pending_pixels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
